@@ hdl/icl_pkg.sv @@
package icl_pkg;

    localparam int UNIT_W = 8;

    // request kinds
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [UNIT_W-1:0] unit_id;
    } req_t;

    typedef struct packed {
        logic [UNIT_W-1:0] entry_unit;
        logic [UNIT_W-1:0] head_unit;
        logic              list_empty;
        logic              empty_error;
    } rsp_t;

endpackage

@@ hdl/index_linked_circular_list_unit.sv @@
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+------------------------------
// request  | in        | req_valid / req_stall (out) | req_data : req_t (type, unit)
// response | out       | rsp_valid / rsp_stall (in)  | rsp_data : rsp_t
//
// One request at a time. A push onto a non-empty list passes through S_LINK1 and
// then S_LINK2, as each link memory has one write port and that push writes two
// entries of each. Link reads are registered synchronous reads.
// Reset clears the head and sets the list empty; link memories are not cleared.
// A stalled response is held in the output register; the request in flight
// waits in its final step until the register frees, then the unit goes idle.
module index_linked_circular_list_unit
    import icl_pkg::*;
#(
    parameter int NUM_UNITS = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam logic [UNIT_W:0] UNIT_LIMIT = (UNIT_W+1)'(NUM_UNITS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LINK1 = 4'b0010,
        S_LINK2 = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // what the accepted request has to do
    typedef enum logic [1:0] {
        K_NOP,
        K_PUSH_FIRST,
        K_PUSH,
        K_REMOVE
    } kind_t;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [UNIT_W-1:0] unit_reg;
    logic [AW-1:0]     last_reg, last_next;
    logic [AW-1:0]     head_reg, head_next;
    logic              empty_reg, empty_next;
    logic              err_reg, err_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;

    // link memories: successor and predecessor of each unit
    logic [AW-1:0] next_mem [NUM_UNITS];
    logic [AW-1:0] prev_mem [NUM_UNITS];
    logic [AW-1:0] next_rd_reg;
    logic [AW-1:0] prev_rd_reg;

    logic          accept;
    logic          in_range;
    logic [AW-1:0] in_idx;
    logic [AW-1:0] prev_raddr;
    logic [AW-1:0] uidx;

    logic          nl_we, pl_we;
    logic [AW-1:0] nl_waddr, nl_wdata;
    logic [AW-1:0] pl_waddr, pl_wdata;

    logic          finish;
    logic          out_free;
    logic          load_rsp;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign in_range  = ({1'b0, req_data.unit_id} < UNIT_LIMIT);
    assign in_idx    = req_data.unit_id[AW-1:0];
    assign uidx      = unit_reg[AW-1:0];

    // a push reads the head's predecessor (the tail); a remove reads both
    // links of the unit itself
    assign prev_raddr = (req_data.req_type == OP_PUSH) ? head_reg : in_idx;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            next_rd_reg <= next_mem[in_idx];
            prev_rd_reg <= prev_mem[prev_raddr];
        end
        if (nl_we)
        begin
            next_mem[nl_waddr] <= nl_wdata;
        end
        if (pl_we)
        begin
            prev_mem[pl_waddr] <= pl_wdata;
        end
    end

    // classification on accept
    always_comb
    begin
        kind_next = kind_reg;
        err_next  = err_reg;
        if (accept)
        begin
            err_next = 1'b0;
            if (!in_range)
            begin
                kind_next = K_NOP;
            end
            else if (req_data.req_type == OP_PUSH)
            begin
                kind_next = empty_reg ? K_PUSH_FIRST : K_PUSH;
            end
            else if (empty_reg)
            begin
                kind_next = K_NOP;
                err_next  = 1'b1;
            end
            else
            begin
                kind_next = K_REMOVE;
            end
        end
    end

    // link updates and head tracking
    always_comb
    begin
        nl_we      = 1'b0;
        nl_waddr   = uidx;
        nl_wdata   = uidx;
        pl_we      = 1'b0;
        pl_waddr   = uidx;
        pl_wdata   = uidx;
        head_next  = head_reg;
        empty_next = empty_reg;
        last_next  = last_reg;
        finish     = 1'b0;

        case (state_reg)
            S_LINK1:
            begin
                case (kind_reg)
                    K_PUSH_FIRST:
                    begin
                        // lone unit links to itself
                        nl_we      = 1'b1;
                        pl_we      = 1'b1;
                        head_next  = uidx;
                        empty_next = 1'b0;
                        finish     = 1'b1;
                    end
                    K_PUSH:
                    begin
                        // new tail: next = head, prev = old tail
                        nl_we     = 1'b1;
                        nl_wdata  = head_reg;
                        pl_we     = 1'b1;
                        pl_wdata  = prev_rd_reg;
                        last_next = prev_rd_reg;
                    end
                    K_REMOVE:
                    begin
                        // bridge predecessor and successor
                        nl_we    = 1'b1;
                        nl_waddr = prev_rd_reg;
                        nl_wdata = next_rd_reg;
                        pl_we    = 1'b1;
                        pl_waddr = next_rd_reg;
                        pl_wdata = prev_rd_reg;
                        if (head_reg == uidx)
                        begin
                            if (next_rd_reg == uidx)
                            begin
                                empty_next = 1'b1;
                                head_next  = '0;
                            end
                            else
                            begin
                                head_next = next_rd_reg;
                            end
                        end
                        finish = 1'b1;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_LINK2:
            begin
                // second writes win where the unit was already tail or head
                nl_we    = 1'b1;
                nl_waddr = last_reg;
                pl_we    = 1'b1;
                pl_waddr = head_reg;
                finish   = 1'b1;
            end
            S_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign load_rsp = finish && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (kind_next == K_NOP) ? S_DONE : S_LINK1;
                end
            end
            S_LINK1:
            begin
                if (kind_reg == K_PUSH)
                begin
                    state_next = S_LINK2;
                end
                else
                begin
                    state_next = load_rsp ? S_IDLE : S_DONE;
                end
            end
            S_LINK2:
            begin
                state_next = load_rsp ? S_IDLE : S_DONE;
            end
            S_DONE:
            begin
                state_next = load_rsp ? S_IDLE : S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_NOP;
            head_reg      <= '0;
            empty_reg     <= 1'b1;
            err_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            err_reg       <= err_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            unit_reg <= req_data.unit_id;
        end
        last_reg <= last_next;
        if (load_rsp)
        begin
            rsp_reg.entry_unit  <= unit_reg;
            rsp_reg.head_unit   <= empty_next ? '0 : UNIT_W'(head_next);
            rsp_reg.list_empty  <= empty_next;
            rsp_reg.empty_error <= err_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
